### sv/grid_a_star_path_search_macros.svh
// Assertion macros for the grid A* path search block.
// Included by the top level; no other dependencies.
`ifndef GRID_A_STAR_PATH_SEARCH_MACROS_SVH
`define GRID_A_STAR_PATH_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define GAPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gaps: assertion failed");
// Next-cycle implication.
`define GAPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gaps: assertion failed");
`else
`define GAPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GAPS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### sv/gaps_pkg.sv
// Shared types, constants and the heuristic table of the grid A* path search.
// No dependencies.
package gaps_pkg;

    localparam int DEF_ROWS  = 4;
    localparam int DEF_COLS  = 16;
    localparam int CELLS     = 64;
    localparam int CELL_W    = 6;
    localparam int ROW_W     = 2;
    localparam int COL_W     = 4;
    localparam int G_W       = 6;
    localparam int TC_W      = 15;
    localparam int CNT_W     = 7;
    localparam int HEUR_W    = 12;
    localparam int FRAC_BITS = 8;
    localparam int MAX_RES   = 63;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [ROW_W-1:0] BASE_ROW_RST  = ROW_W'(3);
    localparam logic [COL_W-1:0] BASE_COL_RST  = COL_W'(15);
    localparam logic [ROW_W-1:0] SPAWN_ROW_RST = ROW_W'(3);
    localparam logic [COL_W-1:0] SPAWN_COL_RST = COL_W'(0);

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_BUILD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ROW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_ROW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_COL = 2'd3;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_INIT, S_NBR, S_CMP, S_PICK, S_SCAN_OL, S_SCAN_TC,
        S_SCAN_CMP, S_POP, S_SHIFT, S_SHIFT_WR, S_GCUR, S_GCUR_LD, S_SEARCH_END,
        S_REPORT, S_WALK_RD, S_WALK_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_WRITE, OP_BLOCK, OP_UNBLOCK, OP_INIT, OP_NBR, OP_CMP,
        OP_PICK, OP_SCAN_OL, OP_SCAN_TC, OP_SCAN_CMP, OP_POP, OP_SHIFT_RD,
        OP_SHIFT_WR, OP_SHIFT_END, OP_GCUR_RD, OP_GCUR_LD, OP_OUT_FAIL,
        OP_OUT_BASE, OP_WALK_INIT, OP_WALK_RD, OP_WALK_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       build_ok;
        logic       init_bad;
        logic       init_goal;
        logic       nbr_cmp;
        logic       d_last;
        logic       cnt_zero;
        logic       scan_last;
        logic       shift_more;
        logic       cur_goal;
        logic       found;
        logic       same_cell;
        logic       walk_last;
        logic       out_free;
    } dp_stat_t;

    typedef logic [HEUR_W-1:0] heur_tab_t [CELLS];

    // Integer square root of (dr^2 + dc^2) << 16, evaluated at elaboration.
    function automatic logic [HEUR_W-1:0] heur_of(input int unsigned dr,
                                                  input int unsigned dc);
        int unsigned v;
        int unsigned r;
        int unsigned b;
        v = (dr * dr + dc * dc) << (2 * FRAC_BITS);
        r = 0;
        b = 32'h4000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return HEUR_W'(r);
    endfunction

    function automatic heur_tab_t heur_build();
        heur_tab_t t;
        for (int i = 0; i < CELLS; i++) begin
            t[i] = heur_of(i >> COL_W, i % (1 << COL_W));
        end
        return t;
    endfunction

    // Indexed by {row distance, column distance}.
    localparam heur_tab_t HEUR_TAB = heur_build();

endpackage

### sv/gaps_ctrl.sv
// Sequencer of the grid A* path search: walks the search and report steps.
// Depends on gaps_pkg; drives the datapath gaps_dp through dp_cmd_t.
module gaps_ctrl import gaps_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   tried_reg, tried_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tried_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            tried_reg <= tried_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        tried_next = tried_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (stat.action)
                    ACT_WRITE: begin
                        cmd.op     = OP_WRITE;
                        state_next = S_IDLE;
                    end
                    ACT_SEARCH: state_next = S_INIT;
                    ACT_BUILD: begin
                        if (stat.build_ok) begin
                            cmd.op     = OP_BLOCK;
                            tried_next = 1'b1;
                        end
                        state_next = S_INIT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_INIT: begin
                cmd.op     = OP_INIT;
                state_next = (stat.init_bad || stat.init_goal) ? S_SEARCH_END : S_NBR;
            end
            S_NBR: begin
                cmd.op = OP_NBR;
                if (stat.nbr_cmp)     state_next = S_CMP;
                else if (stat.d_last) state_next = S_PICK;
            end
            S_CMP: begin
                cmd.op     = OP_CMP;
                state_next = stat.d_last ? S_PICK : S_NBR;
            end
            S_PICK: begin
                if (stat.cnt_zero) begin
                    state_next = S_SEARCH_END;
                end else begin
                    cmd.op     = OP_PICK;
                    state_next = S_SCAN_OL;
                end
            end
            S_SCAN_OL: begin
                cmd.op     = OP_SCAN_OL;
                state_next = S_SCAN_TC;
            end
            S_SCAN_TC: begin
                cmd.op     = OP_SCAN_TC;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                cmd.op     = OP_SCAN_CMP;
                state_next = stat.scan_last ? S_POP : S_SCAN_OL;
            end
            S_POP: begin
                cmd.op     = OP_POP;
                state_next = S_SHIFT;
            end
            S_SHIFT: begin
                if (stat.shift_more) begin
                    cmd.op     = OP_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end else begin
                    cmd.op     = OP_SHIFT_END;
                    state_next = stat.cur_goal ? S_SEARCH_END : S_GCUR;
                end
            end
            S_SHIFT_WR: begin
                cmd.op     = OP_SHIFT_WR;
                state_next = S_SHIFT;
            end
            S_GCUR: begin
                cmd.op     = OP_GCUR_RD;
                state_next = S_GCUR_LD;
            end
            S_GCUR_LD: begin
                cmd.op     = OP_GCUR_LD;
                state_next = S_NBR;
            end
            S_SEARCH_END: begin
                if (tried_reg && !stat.found) begin
                    cmd.op     = OP_UNBLOCK;
                    tried_next = 1'b0;
                    state_next = S_INIT;
                end else begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT: begin
                tried_next = 1'b0;
                if (stat.out_free) begin
                    if (!stat.found) begin
                        cmd.op     = OP_OUT_FAIL;
                        state_next = S_IDLE;
                    end else if (stat.same_cell) begin
                        cmd.op     = OP_OUT_BASE;
                        state_next = S_IDLE;
                    end else begin
                        cmd.op     = OP_WALK_INIT;
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                cmd.op     = OP_WALK_RD;
                state_next = S_WALK_OUT;
            end
            S_WALK_OUT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_WALK_STEP;
                    state_next = stat.walk_last ? S_IDLE : S_WALK_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### sv/gaps_dp.sv
// Datapath of the grid A* path search: map, flags, cost memories, open list.
// Depends on gaps_pkg; commanded by gaps_ctrl.
module gaps_dp import gaps_pkg::*; #(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [1:0]           in_action,
    input  logic [ROW_W-1:0]     in_row,
    input  logic [COL_W-1:0]     in_col,
    input  logic                 in_value,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [ROW_W-1:0]     out_row,
    output logic [COL_W-1:0]     out_col,
    output logic                 out_found,
    output logic                 out_built,
    output logic                 out_last,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    function automatic logic [CELL_W-1:0] cell_of(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        return CELL_W'(int'(r) * COLS + int'(c));
    endfunction

    // configuration
    logic [ROW_W-1:0] base_row_reg, spawn_row_reg;
    logic [COL_W-1:0] base_col_reg, spawn_col_reg;

    // item
    logic [1:0]       act_reg;
    logic [ROW_W-1:0] item_row_reg;
    logic [COL_W-1:0] item_col_reg;
    logic             item_val_reg;

    // search state
    logic [CELLS-1:0]  blocked_reg, open_reg, closed_reg;
    logic [ROW_W-1:0]  cur_row_reg, w_row_reg, best_row_reg;
    logic [COL_W-1:0]  cur_col_reg, w_col_reg, best_col_reg;
    logic [G_W-1:0]    gcur_reg, sc_q_reg;
    logic [1:0]        d_reg, pd_q_reg;
    logic [CNT_W-1:0]  cnt_reg, idx_reg, best_idx_reg;
    logic [TC_W-1:0]   tc_q_reg, best_tc_reg;
    logic [CELL_W-1:0] ol_q_reg;
    logic [CELL_W-1:0] k_reg;
    logic              found_reg;

    // output
    logic             m_tvalid_reg;
    logic [ROW_W-1:0] o_row_reg;
    logic [COL_W-1:0] o_col_reg;
    logic             o_found_reg, o_built_reg, o_last_reg;

    // memories
    logic [G_W-1:0]    sc_mem [CELLS];
    logic [TC_W-1:0]   tc_mem [CELLS];
    logic [1:0]        pd_mem [CELLS];
    logic [CELL_W-1:0] ol_mem [CELLS];

    logic [CELL_W-1:0] item_cell, base_cell, n_cell, cur_cell, best_cell;
    logic              item_in, base_in, spawn_in, special, built_bit;
    logic [ROW_W-1:0]  nr, dr, wr;
    logic [COL_W-1:0]  nc, dc, wc;
    logic              bound, nvalid, n_open, better, ins_new;
    logic [G_W-1:0]    ng;
    logic [TC_W-1:0]   tc_new;
    logic [CNT_W-1:0]  idx_inc;
    logic              upd_we, ol_we, walk_last;
    logic [CELL_W-1:0] ol_waddr, ol_wdata, ol_raddr, sc_raddr;

    assign item_cell = cell_of(item_row_reg, item_col_reg);
    assign base_cell = cell_of(base_row_reg, base_col_reg);
    assign cur_cell  = cell_of(cur_row_reg, cur_col_reg);
    assign best_cell = cell_of(best_row_reg, best_col_reg);
    assign item_in   = (int'(item_row_reg) < ROWS) && (int'(item_col_reg) < COLS);
    assign base_in   = (int'(base_row_reg) < ROWS) && (int'(base_col_reg) < COLS);
    assign spawn_in  = (int'(spawn_row_reg) < ROWS) && (int'(spawn_col_reg) < COLS);
    assign special   = ({item_row_reg, item_col_reg} == {spawn_row_reg, spawn_col_reg})
                    || ({item_row_reg, item_col_reg} == {base_row_reg, base_col_reg});
    assign built_bit = (act_reg == ACT_BUILD) && item_in && blocked_reg[item_cell];

    // neighbor of the current cell in direction d_reg
    always_comb begin
        nr    = cur_row_reg;
        nc    = cur_col_reg;
        bound = 1'b0;
        case (d_reg)
            DIR_UP: begin
                bound = (cur_row_reg != '0);
                nr    = cur_row_reg - ROW_W'(1);
            end
            DIR_DOWN: begin
                bound = (int'(cur_row_reg) + 1 < ROWS);
                nr    = cur_row_reg + ROW_W'(1);
            end
            DIR_LEFT: begin
                bound = (cur_col_reg != '0);
                nc    = cur_col_reg - COL_W'(1);
            end
            default: begin
                bound = (int'(cur_col_reg) + 1 < COLS);
                nc    = cur_col_reg + COL_W'(1);
            end
        endcase
    end

    assign n_cell  = cell_of(nr, nc);
    assign nvalid  = bound && !blocked_reg[n_cell] && !closed_reg[n_cell];
    assign n_open  = open_reg[n_cell];
    assign ins_new = (cmd.op == OP_NBR) && nvalid && !n_open;
    assign ng      = gcur_reg + G_W'(1);
    assign dr      = (nr >= spawn_row_reg) ? nr - spawn_row_reg : spawn_row_reg - nr;
    assign dc      = (nc >= spawn_col_reg) ? nc - spawn_col_reg : spawn_col_reg - nc;
    assign tc_new  = TC_W'({ng, FRAC_BITS'(0)}) + TC_W'(HEUR_TAB[{dr, dc}]);
    assign better  = ng < sc_q_reg;
    assign upd_we  = ins_new || ((cmd.op == OP_CMP) && better);
    assign idx_inc = idx_reg + CNT_W'(1);

    // one step of the walk back along the parent links
    always_comb begin
        wr = w_row_reg;
        wc = w_col_reg;
        case (pd_q_reg)
            DIR_UP:    if (w_row_reg != '0) wr = w_row_reg - ROW_W'(1);
            DIR_DOWN:  if (int'(w_row_reg) + 1 < ROWS) wr = w_row_reg + ROW_W'(1);
            DIR_LEFT:  if (w_col_reg != '0) wc = w_col_reg - COL_W'(1);
            default:   if (int'(w_col_reg) + 1 < COLS) wc = w_col_reg + COL_W'(1);
        endcase
    end
    assign walk_last = ({wr, wc} == {base_row_reg, base_col_reg})
                    || (k_reg == CELL_W'(MAX_RES - 1));

    // memory ports
    always_comb begin
        ol_we    = 1'b0;
        ol_waddr = idx_reg[CELL_W-1:0];
        ol_wdata = ol_q_reg;
        if (ins_new && (cnt_reg < CNT_W'(CELLS))) begin
            ol_we    = 1'b1;
            ol_waddr = cnt_reg[CELL_W-1:0];
            ol_wdata = {nr, nc};
        end else if (cmd.op == OP_SHIFT_WR) begin
            ol_we = 1'b1;
        end
        ol_raddr = (cmd.op == OP_SHIFT_RD) ? idx_inc[CELL_W-1:0] : idx_reg[CELL_W-1:0];
        sc_raddr = (cmd.op == OP_GCUR_RD) ? cur_cell : n_cell;
    end

    always_ff @(posedge aclk) begin
        if (upd_we) begin
            sc_mem[n_cell] <= ng;
            tc_mem[n_cell] <= tc_new;
            pd_mem[n_cell] <= d_reg ^ 2'b01;
        end
        if (ol_we) ol_mem[ol_waddr] <= ol_wdata;
        if (cmd.op == OP_NBR || cmd.op == OP_GCUR_RD) sc_q_reg <= sc_mem[sc_raddr];
        if (cmd.op == OP_SCAN_OL || cmd.op == OP_SHIFT_RD) ol_q_reg <= ol_mem[ol_raddr];
        if (cmd.op == OP_SCAN_TC)
            tc_q_reg <= tc_mem[cell_of(ol_q_reg[CELL_W-1:COL_W], ol_q_reg[COL_W-1:0])];
        if (cmd.op == OP_WALK_RD) pd_q_reg <= pd_mem[cell_of(w_row_reg, w_col_reg)];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                act_reg      <= in_action;
                item_row_reg <= in_row;
                item_col_reg <= in_col;
                item_val_reg <= in_value;
            end
            OP_INIT: begin
                cur_row_reg <= base_row_reg;
                cur_col_reg <= base_col_reg;
                gcur_reg    <= '0;
                d_reg       <= DIR_UP;
            end
            OP_NBR:     if (!(nvalid && n_open)) d_reg <= d_reg + 2'd1;
            OP_CMP:     d_reg <= d_reg + 2'd1;
            OP_PICK:    idx_reg <= '0;
            OP_SCAN_CMP: begin
                if (idx_reg == '0 || tc_q_reg < best_tc_reg) begin
                    best_tc_reg  <= tc_q_reg;
                    best_idx_reg <= idx_reg;
                    best_row_reg <= ol_q_reg[CELL_W-1:COL_W];
                    best_col_reg <= ol_q_reg[COL_W-1:0];
                end
                idx_reg <= idx_inc;
            end
            OP_POP: begin
                cur_row_reg <= best_row_reg;
                cur_col_reg <= best_col_reg;
                idx_reg     <= best_idx_reg;
            end
            OP_SHIFT_WR: idx_reg <= idx_inc;
            OP_GCUR_LD:  gcur_reg <= sc_q_reg;
            OP_WALK_INIT: begin
                w_row_reg <= spawn_row_reg;
                w_col_reg <= spawn_col_reg;
                k_reg     <= '0;
            end
            OP_WALK_STEP: begin
                w_row_reg <= wr;
                w_col_reg <= wc;
                k_reg     <= k_reg + CELL_W'(1);
            end
            default: ;
        endcase
        if (cmd.op == OP_OUT_FAIL) begin
            o_row_reg   <= '0;
            o_col_reg   <= '0;
            o_found_reg <= 1'b0;
            o_built_reg <= built_bit;
            o_last_reg  <= 1'b1;
        end else if (cmd.op == OP_OUT_BASE) begin
            o_row_reg   <= base_row_reg;
            o_col_reg   <= base_col_reg;
            o_found_reg <= 1'b1;
            o_built_reg <= built_bit;
            o_last_reg  <= 1'b1;
        end else if (cmd.op == OP_WALK_STEP) begin
            o_row_reg   <= wr;
            o_col_reg   <= wc;
            o_found_reg <= 1'b1;
            o_built_reg <= built_bit;
            o_last_reg  <= walk_last;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_row_reg  <= BASE_ROW_RST;
            base_col_reg  <= BASE_COL_RST;
            spawn_row_reg <= SPAWN_ROW_RST;
            spawn_col_reg <= SPAWN_COL_RST;
            blocked_reg   <= '0;
            open_reg      <= '0;
            closed_reg    <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BASE_ROW:  base_row_reg  <= cfg_wdata[ROW_W-1:0];
                    CFG_BASE_COL:  base_col_reg  <= cfg_wdata[COL_W-1:0];
                    CFG_SPAWN_ROW: spawn_row_reg <= cfg_wdata[ROW_W-1:0];
                    CFG_SPAWN_COL: spawn_col_reg <= cfg_wdata[COL_W-1:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_WRITE:   if (item_in) blocked_reg[item_cell] <= item_val_reg;
                OP_BLOCK:   blocked_reg[item_cell] <= 1'b1;
                OP_UNBLOCK: blocked_reg[item_cell] <= 1'b0;
                OP_INIT: begin
                    open_reg   <= '0;
                    closed_reg <= CELLS'(1) << base_cell;
                    cnt_reg    <= '0;
                    found_reg  <= base_in && spawn_in
                               && ({base_row_reg, base_col_reg}
                                   == {spawn_row_reg, spawn_col_reg});
                end
                OP_NBR: begin
                    if (ins_new) begin
                        open_reg[n_cell] <= 1'b1;
                        if (cnt_reg < CNT_W'(CELLS)) cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                OP_POP: begin
                    open_reg[best_cell]   <= 1'b0;
                    closed_reg[best_cell] <= 1'b1;
                end
                OP_SHIFT_END: begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (stat.cur_goal) found_reg <= 1'b1;
                end
                default: ;
            endcase
            if (cmd.op == OP_OUT_FAIL || cmd.op == OP_OUT_BASE || cmd.op == OP_WALK_STEP)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_comb begin
        stat.action     = act_reg;
        stat.build_ok   = item_in && !special && !blocked_reg[item_cell];
        stat.init_bad   = !(base_in && spawn_in);
        stat.init_goal  = {base_row_reg, base_col_reg} == {spawn_row_reg, spawn_col_reg};
        stat.nbr_cmp    = nvalid && n_open;
        stat.d_last     = (d_reg == DIR_RIGHT);
        stat.cnt_zero   = (cnt_reg == '0);
        stat.scan_last  = (idx_inc >= cnt_reg);
        stat.shift_more = (idx_inc < cnt_reg);
        stat.cur_goal   = {cur_row_reg, cur_col_reg} == {spawn_row_reg, spawn_col_reg};
        stat.found      = found_reg;
        stat.same_cell  = stat.init_goal;
        stat.walk_last  = walk_last;
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid  = m_tvalid_reg;
    assign out_row   = o_row_reg;
    assign out_col   = o_col_reg;
    assign out_found = o_found_reg;
    assign out_built = o_built_reg;
    assign out_last  = o_last_reg;

endmodule

### sv/grid_a_star_path_search.sv
// Top level of the grid A* path search block.
// Depends on gaps_pkg, gaps_ctrl, gaps_dp and grid_a_star_path_search_macros.svh.
//
// Usage:
//   Input words carry an action in s_tuser: write one blocked bit, search,
//   or try to build on a cell. Writes produce no output word. A search or
//   build produces the path from the spawn cell's parent back to the base
//   cell, one word per cell, with m_tlast on the base cell; a failed search
//   gives one word with found clear and m_tlast set.
//   Base and spawn cells sit on the cfg_* write port; write it only while
//   the block is idle.
//   Each expansion visits the four neighbors, rechecking the cost of those
//   already open, scans the open list for its minimum through the
//   single-port open-list and cost memories and shifts the entries after the
//   pick down by one. A build may run two full searches. Each path word
//   takes a read of the parent-direction memory and an output step.
//   One item is in work at a time; s_tready rises once the last word is
//   loaded into the output register, which may still wait for the receiver.
//   Reset clears the blocked map, loads the default base and spawn cells and
//   drops any pending word. When m_tready is low the output word holds and
//   the walk stalls until it is taken.
`include "grid_a_star_path_search_macros.svh"
module grid_a_star_path_search import gaps_pkg::*; #(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // cell_row[1:0], cell_col[5:2], block_value[6]
    input  logic [1:0]           s_tuser,   // action[1:0]
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // path_row[1:0], path_col[5:2], found[6], built[7]
    output logic                 m_tlast
);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             out_found, out_built;

    // sequencer: one state per memory access of the search and the walk
    gaps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // map, search memories and output register
    gaps_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_action (s_tuser),
        .in_row    (s_tdata[ROW_W-1:0]),
        .in_col    (s_tdata[ROW_W+COL_W-1:ROW_W]),
        .in_value  (s_tdata[ROW_W+COL_W]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_found (out_found),
        .out_built (out_built),
        .out_last  (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign m_tdata = {out_built, out_found, out_col, out_row};

    // an accepted word takes the block out of idle in the next cycle
    `GAPS_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a failed search ends its run in a single word
    `GAPS_ASSERT_IMP(a_fail_is_last, aclk, aresetn, m_tvalid && !m_tdata[6], m_tlast)
    // never load a new word over one the receiver has not taken
    `GAPS_ASSERT_IMP(a_no_overwrite, aclk, aresetn,
        (cmd.op == OP_WALK_STEP || cmd.op == OP_OUT_FAIL || cmd.op == OP_OUT_BASE),
        (!m_tvalid || m_tready))

endmodule

### verif/gaps_path_checker.sv
// Scoreboard for the grid A* path search: watches the config port and both streams.
// It predicts the path words with its own search and compares them. Depends on gaps_pkg.
`timescale 1ns / 100ps
module gaps_path_checker import gaps_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   words_waiting,
    output int                   words_checked,
    output int                   searches_run
);

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             found;
        logic             built;
        logic             last;
    } path_word_t;

    path_word_t path_words_q[$];

    logic [ROW_W-1:0] base_r, spawn_r;
    logic [COL_W-1:0] base_c, spawn_c;
    logic             wall[CELLS];
    logic [G_W-1:0]   g_steps[CELLS];
    logic [TC_W-1:0]  f_cost[CELLS];
    logic [1:0]       cell_flags[CELLS];   // bit0 open, bit1 closed
    logic [1:0]       back_dir[CELLS];
    logic [5:0]       open_q[CELLS];
    int               open_n;

    // Euclidean distance to the spawn cell, 8 fraction bits, truncated.
    function automatic int unsigned dist_to_spawn(int unsigned r, int unsigned c);
        int unsigned dr, dc, v, root, b;
        dr = (r > spawn_r) ? r - spawn_r : spawn_r - r;
        dc = (c > spawn_c) ? c - spawn_c : spawn_c - c;
        v = (dr * dr + dc * dc) << 16;
        root = 0;
        b = 32'h4000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic bit find_path();
        int unsigned goal, cur, r, c, nr, nc, n, ng, best;
        bit ok;
        for (int i = 0; i < CELLS; i++) begin
            g_steps[i] = '0;
            cell_flags[i] = '0;
        end
        open_n = 0;
        searches_run++;
        goal = spawn_r * 16 + spawn_c;
        cur = base_r * 16 + base_c;
        if (cur == goal) return 1'b1;
        cell_flags[cur] = 2'b10;
        while (1) begin
            r = cur / 16;
            c = cur % 16;
            for (int d = 0; d < 4; d++) begin
                nr = r;
                nc = c;
                ok = 1'b1;
                case (d)
                    DIR_UP:    if (r == 0) ok = 1'b0; else nr = r - 1;
                    DIR_DOWN:  if (r + 1 >= 4) ok = 1'b0; else nr = r + 1;
                    DIR_LEFT:  if (c == 0) ok = 1'b0; else nc = c - 1;
                    default:   if (c + 1 >= 16) ok = 1'b0; else nc = c + 1;
                endcase
                if (!ok) continue;
                n = (nr * 16 + nc) % CELLS;
                if (wall[n] || cell_flags[n][1]) continue;
                ng = (g_steps[cur] + 1) % 64;
                if (!cell_flags[n][0] || ng < g_steps[n]) begin
                    back_dir[n] = 2'(d) ^ 2'b01;
                    g_steps[n] = G_W'(ng);
                    f_cost[n] = TC_W'(ng * 256 + dist_to_spawn(nr, nc));
                end
                if (!cell_flags[n][0]) begin
                    if (open_n < CELLS) begin
                        open_q[open_n] = 6'(n);
                        open_n++;
                    end
                    cell_flags[n][0] = 1'b1;
                end
            end
            if (open_n == 0) return 1'b0;
            best = 0;
            for (int i = 1; i < open_n; i++)
                if (f_cost[open_q[i]] < f_cost[open_q[best]]) best = i;
            cur = open_q[best];
            for (int i = best; i + 1 < open_n; i++) open_q[i] = open_q[i + 1];
            open_n--;
            cell_flags[cur] = 2'b10;
            if (cur == goal) return 1'b1;
        end
    endfunction

    // Append one expected word at the tail.
    function automatic void add_word(path_word_t w);
        path_words_q.insert(path_words_q.size(), w);
    endfunction

    // Queue the words of one search outcome: walk parents from spawn to base.
    function automatic void queue_path(bit found, bit built);
        path_word_t w;
        int unsigned pos, home, r, c, k;
        w.found = found;
        w.built = built;
        w.last = 1'b0;
        if (!found) begin
            w.row = '0;
            w.col = '0;
            w.last = 1'b1;
            add_word(w);
            return;
        end
        home = base_r * 16 + base_c;
        pos = spawn_r * 16 + spawn_c;
        if (pos == home) begin
            w.row = base_r;
            w.col = base_c;
            w.last = 1'b1;
            add_word(w);
            return;
        end
        k = 0;
        while (k < MAX_RES) begin
            r = pos / 16;
            c = pos % 16;
            case (back_dir[pos])
                DIR_UP:    if (r > 0) r--;
                DIR_DOWN:  if (r + 1 < 4) r++;
                DIR_LEFT:  if (c > 0) c--;
                default:   if (c + 1 < 16) c++;
            endcase
            pos = r * 16 + c;
            w.row = ROW_W'(r);
            w.col = COL_W'(c);
            add_word(w);
            k++;
            if (pos == home) break;
        end
        path_words_q[$].last = 1'b1;
    endfunction

    function automatic void predict_word(logic [1:0] act, logic [ROW_W-1:0] r,
                                         logic [COL_W-1:0] c, logic v);
        int unsigned idx;
        bit found, special;
        idx = r * 16 + c;
        special = (r == spawn_r && c == spawn_c) || (r == base_r && c == base_c);
        case (act)
            ACT_WRITE:  wall[idx] = v;
            ACT_SEARCH: queue_path(find_path(), 1'b0);
            ACT_BUILD: begin
                if (!special && !wall[idx]) begin
                    wall[idx] = 1'b1;
                    found = find_path();
                    if (!found) begin
                        wall[idx] = 1'b0;
                        found = find_path();
                    end
                end else begin
                    found = find_path();
                end
                queue_path(found, wall[idx]);
            end
            default: ;  // unused action code: drop
        endcase
    endfunction

    always @(posedge aclk) begin
        path_word_t exp_w;
        if (!aresetn) begin
            base_r = BASE_ROW_RST;
            base_c = BASE_COL_RST;
            spawn_r = SPAWN_ROW_RST;
            spawn_c = SPAWN_COL_RST;
            for (int i = 0; i < CELLS; i++) wall[i] = 1'b0;
            path_words_q.delete();
            fail_count <= 0;
            words_checked <= 0;
            searches_run = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_BASE_ROW:  base_r = cfg_wdata[ROW_W-1:0];
                    CFG_BASE_COL:  base_c = cfg_wdata[COL_W-1:0];
                    CFG_SPAWN_ROW: spawn_r = cfg_wdata[ROW_W-1:0];
                    default:       spawn_c = cfg_wdata[COL_W-1:0];
                endcase
            end
            if (s_tvalid && s_tready)
                predict_word(s_tuser, s_tdata[1:0], s_tdata[5:2], s_tdata[6]);
            if (m_tvalid && m_tready) begin
                words_checked <= words_checked + 1;
                if (path_words_q.size() == 0) begin
                    $display("%0t: unexpected word: actual tdata=%h tlast=%b",
                             $time, m_tdata, m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = path_words_q.pop_front();
                    if (m_tdata !== {exp_w.built, exp_w.found, exp_w.col, exp_w.row} ||
                        m_tlast !== exp_w.last) begin
                        $display("%0t: mismatch: expected row=%0d col=%0d found=%b built=%b last=%b, actual row=%0d col=%0d found=%b built=%b last=%b",
                                 $time, exp_w.row, exp_w.col, exp_w.found, exp_w.built,
                                 exp_w.last, m_tdata[1:0], m_tdata[5:2], m_tdata[6],
                                 m_tdata[7], m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        words_waiting <= path_words_q.size();
    end

endmodule

### verif/tb_grid_a_star_path_search.sv
// Top of the grid A* path search testbench: clock, reset, stimulus and verdict.
// Depends on gaps_pkg, the block and gaps_path_checker.
`timescale 1ns / 100ps
module tb_grid_a_star_path_search import gaps_pkg::*;;

    // Slowest item: a build runs two full searches plus up to 63 words under a
    // heavily stalling receiver; take about 150 items many times over.
    localparam int CYCLE_LIMIT = 25_000_000;
    localparam int SETTLE_CYCLES = 60;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;    // cell_row[1:0], cell_col[5:2], block_value[6]
    logic [1:0]           s_tuser = '0;    // action[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;         // path_row[1:0], path_col[5:2], found[6], built[7]
    logic                 m_tlast;

    int fail_count, words_waiting, words_checked, searches_run;
    int tx_idle_pct = 6;
    int rx_idle_pct = 47;
    int cycles = 0;
    int items_sent = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    grid_a_star_path_search u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    gaps_path_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .words_waiting(words_waiting),
        .words_checked(words_checked), .searches_run(searches_run)
    );

    // Receiver: stall at random at the current idle rate.
    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, words_waiting);
            $display("grid_a_star_path_search verification failed");
            $finish;
        end
    end

    // Send one word; called and returning at a rising edge. Hold valid across
    // back-to-back words, drop it only for a random gap.
    task automatic send_word(logic [1:0] act, int unsigned r, int unsigned c, logic v);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {1'b0, v, 4'(c), 2'(r)};
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        @(posedge aclk);
        items_sent++;
    endtask

    // Wait until every expected word has arrived and the block has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_waiting != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_cells(int unsigned br, int unsigned bc, int unsigned sr,
                             int unsigned sc);
        write_reg(CFG_BASE_ROW, br);
        write_reg(CFG_BASE_COL, bc);
        write_reg(CFG_SPAWN_ROW, sr);
        write_reg(CFG_SPAWN_COL, sc);
        @(posedge aclk);
    endtask

    // Mostly builds and searches over a sparse random map; walls stay rare so
    // paths stay long and builds sometimes have to back out.
    task automatic random_items(int n);
        int unsigned pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 35)
                send_word(ACT_WRITE, $urandom_range(3), $urandom_range(15),
                          $urandom_range(99) < 35);
            else if (pick < 72)
                send_word(ACT_BUILD, $urandom_range(3), $urandom_range(15),
                          1'($urandom_range(1)));
            else if (pick < 95)
                send_word(ACT_SEARCH, $urandom_range(3), $urandom_range(15),
                          1'($urandom_range(1)));
            else begin
                send_word(2'd3, $urandom_range(3), $urandom_range(15),
                          1'($urandom_range(1)));
                i--;   // ignored words do not count
            end
        end
    endtask

    task automatic clear_map();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 16; c++) send_word(ACT_WRITE, r, c, 1'b0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: default cells, base (3,15) to spawn (3,0).
        send_word(ACT_SEARCH, 0, 0, 1'b0);
        send_word(ACT_WRITE, 3, 7, 1'b1);
        send_word(ACT_SEARCH, 0, 0, 1'b0);          // detour around one wall
        send_word(ACT_BUILD, 2, 7, 1'b0);           // build that keeps a path
        send_word(ACT_BUILD, 3, 0, 1'b0);           // refused: spawn cell
        send_word(ACT_BUILD, 3, 15, 1'b0);          // refused: base cell
        send_word(ACT_BUILD, 3, 7, 1'b0);           // refused: already blocked
        send_word(ACT_WRITE, 1, 8, 1'b1);
        send_word(ACT_WRITE, 2, 8, 1'b1);
        send_word(ACT_WRITE, 3, 8, 1'b1);
        send_word(ACT_BUILD, 0, 8, 1'b1);           // would cut the grid: backs out
        send_word(2'd3, 1, 1, 1'b1);                // unused action: no word
        send_word(ACT_WRITE, 3, 0, 1'b1);
        send_word(ACT_SEARCH, 0, 0, 1'b0);          // blocked spawn: no path
        send_word(ACT_WRITE, 3, 0, 1'b0);
        send_word(ACT_WRITE, 3, 15, 1'b1);
        send_word(ACT_SEARCH, 0, 0, 1'b0);          // blocked base still starts
        send_word(ACT_WRITE, 3, 15, 1'b0);
        send_word(ACT_WRITE, 0, 8, 1'b1);
        send_word(ACT_BUILD, 1, 1, 1'b0);           // walled off: plain no-path
        drain();

        // Spawn on the base cell gives a single word.
        set_cells(3, 15, 3, 15);
        send_word(ACT_SEARCH, 0, 0, 1'b0);
        send_word(ACT_BUILD, 3, 15, 1'b0);
        clear_map();
        drain();

        // Phase 1: corner to corner, receiver stalls often.
        set_cells(0, 0, 3, 15);
        random_items(22);
        drain();

        // Phase 2: swap idling, opposite corners, map carried over.
        tx_idle_pct = 47;
        rx_idle_pct = 6;
        set_cells(0, 15, 3, 0);
        random_items(22);
        drain();

        // Phase 3: no idling, inner cells, map carried over.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_cells(1, 3, 2, 12);
        random_items(22);
        drain();

        $display("sent %0d input words, checked %0d path words over %0d predicted searches",
                 items_sent, words_checked, searches_run);
        $display("five base/spawn settings including the grid corners, three idle mixes");
        if (fail_count == 0)
            $display("grid_a_star_path_search verification clean");
        else
            $display("grid_a_star_path_search verification failed");
        $finish;
    end

endmodule
